[rtl/cdsd_pkg.sv]
`timescale 1ns / 1ps

package cdsd_pkg;

  // default sizes and register values
  localparam int DECK_SIZE_DEF = 52;
  localparam int PASSES_DEF    = 25;

  // fixed field widths
  localparam int CODE_W  = 6;
  localparam int RAND_W  = 32;
  localparam int CMD_W   = 3;
  localparam int PASS_W  = 8;
  localparam int STAT_W  = 2;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // commands
  localparam logic [CMD_W-1:0] CMD_NEW      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SHUFFLE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEAL     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_VALIDATE = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_IDX = 2'd2;
  localparam logic [STAT_W-1:0] ST_DAMAGED = 2'd3;

  // register index, taken from the word address bit
  localparam logic REG_PASSES = 1'b0;

  // request from the sequencer to the deck store
  typedef struct packed {
    logic              clear;
    logic              we;
    logic [CODE_W-1:0] waddr;
    logic [CODE_W-1:0] wdata;
    logic [CODE_W-1:0] raddr_a;
    logic [CODE_W-1:0] raddr_b;
  } store_req_t;

endpackage

[rtl/cdsd_mod.sv]
`timescale 1ns / 1ps

module cdsd_mod #(
  parameter int DECK_SIZE = cdsd_pkg::DECK_SIZE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [cdsd_pkg::RAND_W-1:0]          dividend,
  input  logic [$clog2(DECK_SIZE+1)-1:0]       divisor,
  output logic                                 busy,
  output logic                                 done,
  output logic [$clog2(DECK_SIZE)-1:0]         result
);

  localparam int DW   = $clog2(DECK_SIZE + 1);
  localparam int AW   = $clog2(DECK_SIZE);
  localparam int RW   = cdsd_pkg::RAND_W;
  localparam int CNTW = $clog2(RW);
  localparam logic [CNTW-1:0] LAST = CNTW'(RW - 1);

  logic [RW-1:0]   sh;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   div_q;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;
  logic [DW-1:0]   rem_next;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, sh[RW-1]};
    diff     = trial - {1'b0, div_q};
    ge       = trial >= {1'b0, div_q};
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start) begin
      sh    <= dividend;
      rem   <= '0;
      div_q <= divisor;
    end else if (busy) begin
      sh  <= {sh[RW-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = AW'(rem);

endmodule

[rtl/cdsd_store.sv]
`timescale 1ns / 1ps

module cdsd_store #(
  parameter int DECK_SIZE = cdsd_pkg::DECK_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cdsd_pkg::store_req_t        req,
  output logic [cdsd_pkg::CODE_W-1:0] rd_a,
  output logic [cdsd_pkg::CODE_W-1:0] rd_b
);

  localparam int AW = $clog2(DECK_SIZE);
  localparam int CW = cdsd_pkg::CODE_W;

  logic [CW-1:0]        mem [DECK_SIZE];
  logic [DECK_SIZE-1:0] written;
  logic [CW-1:0]        mem_a;
  logic [CW-1:0]        mem_b;
  logic                 hit_a;
  logic                 hit_b;
  logic [AW-1:0]        addr_a_q;
  logic [AW-1:0]        addr_b_q;

  // deck memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    mem_a    <= mem[req.raddr_a[AW-1:0]];
    mem_b    <= mem[req.raddr_b[AW-1:0]];
    hit_a    <= written[req.raddr_a[AW-1:0]];
    hit_b    <= written[req.raddr_b[AW-1:0]];
    addr_a_q <= req.raddr_a[AW-1:0];
    addr_b_q <= req.raddr_b[AW-1:0];
  end

  // written flags, an unwritten entry holds its ordered code
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.clear) begin
      written <= '0;
    end else if (req.we) begin
      written[req.waddr[AW-1:0]] <= 1'b1;
    end
  end

  assign rd_a = hit_a ? mem_a : CW'(addr_a_q);
  assign rd_b = hit_b ? mem_b : CW'(addr_b_q);

endmodule

[rtl/card_deck_shuffle_deal.sv]
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in        to block   in_valid / in_stall  cmd, random_word, card_position
// out       from block out_valid/out_stall  card_code, card_valid, status,
//                                           cards_remaining, shuffle_done
// config    to block   APB psel/penable     paddr, pwdata, prdata
//
// one item at a time; in_stall is high from acceptance until the result is loaded
// new deck, deal, read: EXEC, then a store read for deal and read, then FIN; shuffle
// step: EXEC, the 32-step remainder unit in MOD, two store writes, FIN; validate:
// one store read per cycle over the deck, then FIN
// a finished result waits in the output register while the next item is taken
// rst is synchronous; the deck reads as ordered after reset with no clearing pass

module card_deck_shuffle_deal #(
  parameter int DECK_SIZE = cdsd_pkg::DECK_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cdsd_pkg::CMD_W-1:0]    cmd,
  input  logic [cdsd_pkg::RAND_W-1:0]   random_word,
  input  logic [cdsd_pkg::CODE_W-1:0]   card_position,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cdsd_pkg::CODE_W-1:0]   card_code,
  output logic                          card_valid,
  output logic [cdsd_pkg::STAT_W-1:0]   status,
  output logic [cdsd_pkg::CODE_W-1:0]   cards_remaining,
  output logic                          shuffle_done,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cdsd_pkg::APB_AW-1:0]   paddr,
  input  logic [cdsd_pkg::APB_DW-1:0]   pwdata,
  output logic [cdsd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(DECK_SIZE);
  localparam int PW = $clog2(DECK_SIZE + 1);
  localparam int CW = cdsd_pkg::CODE_W;
  localparam int NW = cdsd_pkg::PASS_W;
  localparam int SW = cdsd_pkg::STAT_W;
  localparam int DWB = cdsd_pkg::APB_DW;
  localparam logic [PW-1:0] DECK_P = PW'(DECK_SIZE);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXEC    = 4'd1;
  localparam logic [3:0] S_RD_DEAL = 4'd2;
  localparam logic [3:0] S_RD_CARD = 4'd3;
  localparam logic [3:0] S_MOD     = 4'd4;
  localparam logic [3:0] S_SW_WA   = 4'd5;
  localparam logic [3:0] S_SW_WB   = 4'd6;
  localparam logic [3:0] S_VAL     = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  logic [3:0]                   state;
  logic [cdsd_pkg::CMD_W-1:0]   cmd_q;
  logic [cdsd_pkg::RAND_W-1:0]  rnd_q;
  logic [CW-1:0]                pos_q;
  logic [NW-1:0]                shuffle_passes;
  logic [PW-1:0]                deal_pointer;
  logic [AW-1:0]                swap_cursor;
  logic [NW-1:0]                passes_left;
  logic                         shuffle_active;
  logic [AW-1:0]                i_q;
  logic [CW-1:0]                a_q;
  logic [CW-1:0]                b_q;
  logic [CW-1:0]                hold;
  logic [PW-1:0]                vk;
  logic                         vpend;
  logic                         damaged;
  logic [DECK_SIZE-1:0]         seen;
  logic [CW-1:0]                res_code;
  logic                         res_valid;
  logic [SW-1:0]                res_status;
  logic                         res_done;

  logic [PW-1:0]                remaining;
  logic [AW-1:0]                i_eff;
  logic [PW:0]                  a_sum;
  logic [PW-1:0]                b_sum;
  logic [NW-1:0]                pl_next;
  logic                         mod_start;
  logic [PW-1:0]                mod_div;
  logic                         mod_busy;
  logic                         mod_done;
  logic [AW-1:0]                mod_j;
  logic                         cfg_wr;
  logic                         out_load;
  cdsd_pkg::store_req_t         req;
  logic [CW-1:0]                rd_a;
  logic [CW-1:0]                rd_b;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == cdsd_pkg::REG_PASSES);
  assign prdata = (paddr[2] == cdsd_pkg::REG_PASSES) ? DWB'(shuffle_passes) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      shuffle_passes <= NW'(cdsd_pkg::PASSES_DEF);
    end else if (cfg_wr) begin
      shuffle_passes <= pwdata[NW-1:0];
    end
  end

  // shuffle arithmetic helpers
  always_comb begin
    remaining = DECK_P - deal_pointer;
    i_eff     = shuffle_active ? swap_cursor : AW'(remaining - 1'b1);
    a_sum     = {1'b0, deal_pointer} + (PW+1)'(i_eff);
    b_sum     = deal_pointer + PW'(mod_j);
    pl_next   = passes_left - 1'b1;
    mod_div   = PW'(i_eff) + 1'b1;
    mod_start = (state == S_EXEC) && (cmd_q == cdsd_pkg::CMD_SHUFFLE) &&
                !(!shuffle_active && (remaining < PW'(2) || shuffle_passes == '0)) &&
                !(i_eff == '0 || a_sum >= (PW+1)'(DECK_SIZE));
  end

  // store requests per state
  always_comb begin
    req         = '0;
    req.raddr_a = a_q;
    req.raddr_b = b_q;
    case (state)
      S_EXEC: begin
        if (cmd_q == cdsd_pkg::CMD_NEW) begin
          req.clear = 1'b1;
        end else if (cmd_q == cdsd_pkg::CMD_DEAL) begin
          req.raddr_a = CW'(deal_pointer);
        end else if (cmd_q == cdsd_pkg::CMD_READ) begin
          req.raddr_a = pos_q;
        end
      end
      S_MOD: begin
        req.raddr_b = CW'(b_sum);
      end
      S_SW_WA: begin
        req.we    = 1'b1;
        req.waddr = a_q;
        req.wdata = rd_b;
      end
      S_SW_WB: begin
        req.we    = 1'b1;
        req.waddr = b_q;
        req.wdata = hold;
      end
      S_VAL: begin
        req.raddr_a = CW'(vk);
      end
      default: begin
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      deal_pointer   <= '0;
      swap_cursor    <= '0;
      passes_left    <= '0;
      shuffle_active <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q <= cmd;
            rnd_q <= random_word;
            pos_q <= card_position;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_code   <= '0;
          res_valid  <= 1'b0;
          res_status <= cdsd_pkg::ST_OK;
          res_done   <= 1'b0;
          state      <= S_FIN;
          case (cmd_q)
            cdsd_pkg::CMD_NEW: begin
              deal_pointer   <= '0;
              swap_cursor    <= '0;
              passes_left    <= '0;
              shuffle_active <= 1'b0;
            end
            cdsd_pkg::CMD_SHUFFLE: begin
              if (!shuffle_active && (remaining < PW'(2) || shuffle_passes == '0)) begin
                res_done <= 1'b1;
              end else begin
                if (!shuffle_active) begin
                  shuffle_active <= 1'b1;
                  passes_left    <= shuffle_passes;
                  swap_cursor    <= i_eff;
                end
                if (i_eff == '0 || a_sum >= (PW+1)'(DECK_SIZE)) begin
                  shuffle_active <= 1'b0;
                  res_done       <= 1'b1;
                end else begin
                  i_q   <= i_eff;
                  a_q   <= CW'(a_sum);
                  state <= S_MOD;
                end
              end
            end
            cdsd_pkg::CMD_DEAL: begin
              shuffle_active <= 1'b0;
              if (deal_pointer >= DECK_P) begin
                res_status <= cdsd_pkg::ST_EMPTY;
              end else begin
                state <= S_RD_DEAL;
              end
            end
            cdsd_pkg::CMD_READ: begin
              if (32'(pos_q) >= 32'(DECK_SIZE)) begin
                res_status <= cdsd_pkg::ST_BAD_IDX;
              end else begin
                state <= S_RD_CARD;
              end
            end
            cdsd_pkg::CMD_VALIDATE: begin
              seen    <= '0;
              vk      <= '0;
              vpend   <= 1'b0;
              damaged <= 1'b0;
              state   <= S_VAL;
            end
            default: begin
            end
          endcase
        end
        S_RD_DEAL: begin
          res_code     <= rd_a;
          res_valid    <= 1'b1;
          deal_pointer <= deal_pointer + 1'b1;
          state        <= S_FIN;
        end
        S_RD_CARD: begin
          res_code  <= rd_a;
          res_valid <= 1'b1;
          state     <= S_FIN;
        end
        S_MOD: begin
          if (mod_done) begin
            b_q   <= CW'(b_sum);
            state <= S_SW_WA;
          end
        end
        S_SW_WA: begin
          hold  <= rd_a;
          state <= S_SW_WB;
        end
        S_SW_WB: begin
          // advance the cursor, count a pass when it reaches zero
          if (i_q == AW'(1)) begin
            passes_left <= pl_next;
            if (pl_next == '0) begin
              shuffle_active <= 1'b0;
              res_done       <= 1'b1;
              swap_cursor    <= '0;
            end else begin
              swap_cursor <= AW'(remaining - 1'b1);
            end
          end else begin
            swap_cursor <= i_q - 1'b1;
          end
          state <= S_FIN;
        end
        S_VAL: begin
          // read one entry per cycle, check the one read the cycle before
          vpend <= (vk < DECK_P);
          if (vk < DECK_P) begin
            vk <= vk + 1'b1;
          end
          if (vpend) begin
            if (32'(rd_a) >= 32'(DECK_SIZE)) begin
              damaged <= 1'b1;
            end else begin
              if (seen[rd_a[AW-1:0]]) begin
                damaged <= 1'b1;
              end
              seen[rd_a[AW-1:0]] <= 1'b1;
            end
          end
          if (!vpend && vk == DECK_P) begin
            res_status <= damaged ? cdsd_pkg::ST_DAMAGED : cdsd_pkg::ST_OK;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      card_code       <= res_code;
      card_valid      <= res_valid;
      status          <= res_status;
      shuffle_done    <= res_done;
      cards_remaining <= CW'(remaining);
    end
  end

  cdsd_mod #(
    .DECK_SIZE (DECK_SIZE)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (rnd_q),
    .divisor  (mod_div),
    .busy     (mod_busy),
    .done     (mod_done),
    .result   (mod_j)
  );

  cdsd_store #(
    .DECK_SIZE (DECK_SIZE)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took an item but did not go busy");

  a_active_has_passes: assert property (@(posedge clk) disable iff (rst)
    shuffle_active |-> passes_left != '0)
    else $error("shuffle active with no passes left");

  a_deal_in_range: assert property (@(posedge clk) disable iff (rst)
    deal_pointer <= DECK_P)
    else $error("deal pointer past the deck");

  a_mod_in_range: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (mod_j <= i_q) && (state == S_MOD) && !mod_busy)
    else $error("swap partner outside the undealt range");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result loaded outside the finish state");
`endif

endmodule
